[design/att_pkg.sv]
package att_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int MAX_HEIGHT  = 6;
  localparam int IDX_BITS    = 6;
  localparam int STORE_DEPTH = 63;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 3;

  localparam logic [1:0] MODE_PRE  = 2'd0;
  localparam logic [1:0] MODE_IN   = 2'd1;
  localparam logic [1:0] MODE_POST = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_WALK_MODE   = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TREE_HEIGHT = 1'd1;

  localparam logic [1:0] WALK_MODE_RST   = MODE_IN;
  localparam logic [2:0] TREE_HEIGHT_RST = 3'd3;

  typedef enum logic {
    ST_LOAD,
    ST_WALK
  } att_state_e;

  typedef struct packed {
    logic                wr_en;
    logic [IDX_BITS-1:0] wr_addr;
    logic                rd_en;
    logic [IDX_BITS-1:0] rd_addr;
    logic                rd_last;
  } att_cmd_t;

  typedef struct packed {
    logic rd_room;
  } att_sts_t;

  // number of consecutive ones from bit 0 up
  function automatic logic [2:0] trail_ones(logic [IDX_BITS-1:0] v);
    logic [2:0] n;
    logic       run;
    n   = '0;
    run = 1'b1;
    for (int b = 0; b < IDX_BITS; b++) begin
      if (run && v[b]) begin
        n = n + 3'd1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // position of the lowest set bit
  function automatic logic [2:0] trail_zeros(logic [IDX_BITS-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int b = IDX_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        r = 3'(b);
      end
    end
    return r;
  endfunction

  // position of the highest set bit
  function automatic logic [2:0] floor_log2(logic [IDX_BITS-1:0] v);
    logic [2:0] r;
    r = '0;
    for (int b = 0; b < IDX_BITS; b++) begin
      if (v[b]) begin
        r = 3'(b);
      end
    end
    return r;
  endfunction

endpackage

[design/array_tree_traversal_order.sv]
// Perfect binary tree walker.
// The slave stream takes node values in level order (node i has children
// 2i+1 and 2i+2), one transfer per cycle. The tree holds 2^h-1 nodes, h set
// by the tree_height register (0 reads as 1, above 6 as 6). The transfer of
// the last node starts a walk in preorder, inorder or postorder per the
// walk_mode register (mode three walks inorder); every stored value leaves
// on the master stream, tlast marking the final visit.
// The last node transfer moves to the walk state, whose reads pass the read
// register and output queue; visits follow one per cycle while the receiver
// keeps up, set by the single read port of the node store and a two-entry
// output queue. s_axis_tready is low while the walk issues its n reads, and
// the next tree may load while the tail of the walk drains. When the receiver
// stalls, the walk pauses with at most two visits queued and none is lost.
// Registers are written on the always-ready cfg channel (index 0 mode, 1
// height); the user must use it only while the block is idle (not enforced).
// Reset clears the load count, empties the output and sets inorder, height 3;
// the node store is not cleared.
module array_tree_traversal_order (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [att_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [att_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic signed [att_pkg::VALUE_BITS-1:0] s_axis_tdata,   // node_value
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic signed [att_pkg::VALUE_BITS-1:0] m_axis_tdata,   // visit_value
  output logic                                  m_axis_tlast    // final_visit
);
  import att_pkg::*;

  logic [1:0] walk_mode_q;
  logic [2:0] tree_height_q;
  att_cmd_t   cmd;
  att_sts_t   sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_mode_q   <= WALK_MODE_RST;
      tree_height_q <= TREE_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WALK_MODE:   walk_mode_q   <= cfg_data_i[1:0];
        REG_TREE_HEIGHT: tree_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  att_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .walk_mode_i   (walk_mode_q),
    .tree_height_i (tree_height_q),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_o         (cmd),
    .sts_i         (sts)
  );

  att_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .wr_data_i     (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_load_walk_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && cmd.rd_en))
    else $error("read issued while loading");

  a_last_read_ends_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.rd_en && cmd.rd_last) |=> s_axis_tready)
    else $error("walk did not end after its final read");

  a_wr_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr_en |-> (cmd.wr_addr != IDX_BITS'(STORE_DEPTH)))
    else $error("node store write beyond depth");
`endif

endmodule

[design/att_dp.sv]
module att_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  att_pkg::att_cmd_t                   cmd_i,
  output att_pkg::att_sts_t                   sts_o,
  input  logic signed [att_pkg::VALUE_BITS-1:0] wr_data_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic signed [att_pkg::VALUE_BITS-1:0] m_axis_tdata,  // visit_value
  output logic                                m_axis_tlast     // final_visit
);
  import att_pkg::*;

  logic signed [VALUE_BITS-1:0] mem [STORE_DEPTH];

  logic signed [VALUE_BITS-1:0] rd_data_q;
  logic                         rd_last_q;
  logic                         rd_v_q;

  // two-entry output queue covers the read latency at full rate
  logic signed [VALUE_BITS-1:0] fifo_data_q [2];
  logic                         fifo_last_q [2];
  logic                         wr_ptr_q, rd_ptr_q;
  logic [1:0]                   cnt_q, cnt_d;
  logic                         push, pop;
  logic [1:0]                   pending;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.rd_addr];
      rd_last_q <= cmd_i.rd_last;
    end
    if (push) begin
      fifo_data_q[wr_ptr_q] <= rd_data_q;
      fifo_last_q[wr_ptr_q] <= rd_last_q;
    end
  end

  assign push = rd_v_q;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // entries held or on their way, minus the one leaving now
  assign pending       = cnt_q + {1'b0, rd_v_q} - {1'b0, pop};
  assign sts_o.rd_room = (pending <= 2'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q   <= 1'b0;
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.rd_en;
      cnt_q  <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = fifo_data_q[rd_ptr_q];
  assign m_axis_tlast  = fifo_last_q[rd_ptr_q];

endmodule

[design/att_ctrl.sv]
module att_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        walk_mode_i,
  input  logic [2:0]        tree_height_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output att_pkg::att_cmd_t cmd_o,
  input  att_pkg::att_sts_t sts_i
);
  import att_pkg::*;

  att_state_e state_q, state_d;

  logic [IDX_BITS-1:0] load_cnt_q, load_cnt_d;
  logic [IDX_BITS-1:0] visit_q, visit_d;
  logic [IDX_BITS-1:0] node_q, node_d;   // 1-based heap number for pre/postorder

  logic [2:0]          height;
  logic [IDX_BITS-1:0] nodes;
  logic                load_done;

  logic [IDX_BITS-1:0] in_pos;
  logic [2:0]          in_tz;
  logic [2:0]          in_depth;
  logic [IDX_BITS-1:0] in_node;

  logic [IDX_BITS-1:0] cur_node;
  logic [2:0]          cur_depth;
  logic [IDX_BITS-1:0] pre_next;
  logic [IDX_BITS-1:0] post_sib;
  logic [IDX_BITS-1:0] post_next;
  logic [IDX_BITS-1:0] start_node;
  logic                is_last;

  always_comb begin
    if (tree_height_i == 3'd0) begin
      height = 3'd1;
    end else if (tree_height_i > 3'(MAX_HEIGHT)) begin
      height = 3'(MAX_HEIGHT);
    end else begin
      height = tree_height_i;
    end
  end

  assign nodes     = IDX_BITS'((7'd1 << height) - 7'd1);
  assign load_done = ({1'b0, load_cnt_q} + 7'd1) >= {1'b0, nodes};

  // inorder position p sits at depth h-1-tz(p), index p>>(tz+1) in its level
  assign in_pos   = visit_q + IDX_BITS'(1);
  assign in_tz    = trail_zeros(in_pos);
  assign in_depth = height - 3'd1 - in_tz;
  assign in_node  = (IDX_BITS'(1) << in_depth) | (in_pos >> (in_tz + 3'd1));

  assign cur_node  = (walk_mode_i == MODE_PRE || walk_mode_i == MODE_POST) ? node_q : in_node;
  assign cur_depth = floor_log2(node_q);

  // preorder: go left until a leaf, then climb out of right children to the sibling
  always_comb begin
    if (cur_depth < height - 3'd1) begin
      pre_next = node_q << 1;
    end else begin
      pre_next = (node_q >> trail_ones(node_q)) + IDX_BITS'(1);
    end
  end

  // postorder: a right child goes to its parent, a left child to the leftmost
  // leaf under its sibling
  assign post_sib = node_q + IDX_BITS'(1);
  always_comb begin
    if (node_q[0]) begin
      post_next = node_q >> 1;
    end else begin
      post_next = post_sib << (height - 3'd1 - floor_log2(post_sib));
    end
  end

  assign start_node = (walk_mode_i == MODE_POST) ? (IDX_BITS'(1) << (height - 3'd1))
                                                : IDX_BITS'(1);
  assign is_last    = (visit_q == nodes - IDX_BITS'(1));

  always_comb begin
    state_d       = state_q;
    load_cnt_d    = load_cnt_q;
    visit_d       = visit_q;
    node_d        = node_q;
    in_ready_o    = 1'b0;
    cmd_o.wr_en   = 1'b0;
    cmd_o.wr_addr = load_cnt_q;
    cmd_o.rd_en   = 1'b0;
    cmd_o.rd_addr = cur_node - IDX_BITS'(1);
    cmd_o.rd_last = is_last;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.wr_en = in_valid_i;
        if (in_valid_i) begin
          if (load_done) begin
            load_cnt_d = '0;
            visit_d    = '0;
            node_d     = start_node;
            state_d    = ST_WALK;
          end else begin
            load_cnt_d = load_cnt_q + IDX_BITS'(1);
          end
        end
      end
      ST_WALK: begin
        cmd_o.rd_en = sts_i.rd_room;
        if (sts_i.rd_room) begin
          if (is_last) begin
            state_d = ST_LOAD;
          end else begin
            visit_d = visit_q + IDX_BITS'(1);
            node_d  = (walk_mode_i == MODE_POST) ? post_next : pre_next;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      visit_q    <= '0;
      node_q     <= IDX_BITS'(1);
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      visit_q    <= visit_d;
      node_q     <= node_d;
    end
  end

endmodule
